>>> hdl/upc_pkg.sv
// Shared types, constants and character helpers for the URI percent codec.
// No dependencies; imported by the front end, queue, back end, top level and testbench.
package upc_pkg;

   // Register indexes on the configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAFE_SET  = 1'b1;

   // Default number of jobs held between the front and back ends.
   localparam int UPC_QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   // Element n of this table is the upper-case hex digit for nibble n.
   localparam logic [15:0][7:0] HEX_UPPER = "FEDCBA9876543210";

   // Decoder held-count codes.
   localparam logic [1:0] HELD_NONE    = 2'd0;
   localparam logic [1:0] HELD_PERCENT = 2'd1;
   localparam logic [1:0] HELD_DIGIT   = 2'd2;

   typedef struct packed {
      logic direction;   // 1 encodes, 0 decodes
      logic safe_set;    // 1 adds hyphen, dot and tilde to the safe set
   } cfg_type;

   // Bytes released by one input item, in output order from index 0.
   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      count;     // 1 to 3
      logic            str_end;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
               (c >= "a" && c <= "f");
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      if (c >= "0" && c <= "9") begin
         v = c - 8'h30;
      end else if (c >= "A" && c <= "F") begin
         v = c - 8'h37;
      end else begin
         v = c - 8'h57;
      end
      hex_value = v[3:0];
   endfunction

   function automatic logic is_safe(input logic [7:0] c, input logic ext);
      is_safe = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                (c >= "a" && c <= "z") || (c == "_") ||
                (ext && (c == "-" || c == "." || c == "~"));
   endfunction

endpackage

>>> hdl/upc_req_if.sv
// Input channel of the URI percent codec: one string byte per beat.
// Depends on nothing.
interface upc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       string_end;

   modport source (output valid, output in_byte, output string_end, input ready);
   modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

>>> hdl/upc_rsp_if.sv
// Result channel of the URI percent codec: one output byte per beat.
// Depends on nothing.
interface upc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       out_end;

   modport source (output valid, output out_byte, output run_last, output out_end,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input out_end,
                   output ready);
endinterface

>>> hdl/upc_front.sv
// Front end: accepts input beats, keeps the decoder escape state and builds
// one job of up to three output bytes per item. Uses upc_pkg and upc_req_if.
module upc_front
   import upc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   upc_req_if.sink         req,
   input  fifo_status_type fifo_status,
   output logic            push,
   output job_type         push_job
);

   logic [1:0] held_count_ff, held_count_in;
   logic [7:0] held_digit_ff, held_digit_in;
   logic       accept;

   assign req.ready = !fifo_status.full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      logic [3:0][7:0] emit_bytes;
      logic [1:0]      n;
      logic [1:0]      hc;
      logic [7:0]      b;
      logic            fresh;

      emit_bytes    = '0;
      n             = 2'd0;
      hc            = held_count_ff;
      b             = req.in_byte;
      fresh         = 1'b0;
      held_digit_in = held_digit_ff;

      if (cfg.direction) begin
         hc = HELD_NONE;
         if (is_safe(b, cfg.safe_set)) begin
            emit_bytes[0] = b;
            n = 2'd1;
         end else begin
            emit_bytes[0] = CHAR_PERCENT;
            emit_bytes[1] = HEX_UPPER[b[7:4]];
            emit_bytes[2] = HEX_UPPER[b[3:0]];
            n = 2'd3;
         end
      end else begin
         if (hc == HELD_PERCENT) begin
            if (is_hex(b)) begin
               held_digit_in = b;
               hc = HELD_DIGIT;
            end else begin
               emit_bytes[n] = CHAR_PERCENT;
               n = n + 2'd1;
               fresh = 1'b1;
            end
         end else if (hc == HELD_DIGIT) begin
            if (is_hex(b)) begin
               emit_bytes[n] = {hex_value(held_digit_ff), hex_value(b)};
               n = n + 2'd1;
               hc = HELD_NONE;
            end else begin
               emit_bytes[n] = CHAR_PERCENT;
               n = n + 2'd1;
               emit_bytes[n] = held_digit_ff;
               n = n + 2'd1;
               fresh = 1'b1;
            end
         end else begin
            fresh = 1'b1;
         end

         // A byte taken with nothing pending: a percent sign opens an escape.
         if (fresh) begin
            if (b == CHAR_PERCENT) begin
               hc = HELD_PERCENT;
            end else begin
               hc = HELD_NONE;
               emit_bytes[n] = b;
               n = n + 2'd1;
            end
         end

         // At the end of the string any half-read escape leaves as it came.
         if (req.string_end) begin
            if (hc == HELD_PERCENT) begin
               emit_bytes[n] = CHAR_PERCENT;
               n = n + 2'd1;
            end else if (hc == HELD_DIGIT) begin
               emit_bytes[n] = CHAR_PERCENT;
               n = n + 2'd1;
               emit_bytes[n] = held_digit_in;
               n = n + 2'd1;
            end
            hc = HELD_NONE;
         end
      end

      held_count_in    = accept ? hc : held_count_ff;
      if (!accept) begin
         held_digit_in = held_digit_ff;
      end
      push_job.bytes   = emit_bytes[2:0];
      push_job.count   = n;
      push_job.str_end = req.string_end;
      push             = accept && (n != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= HELD_NONE;
         held_digit_ff <= '0;
      end else begin
         held_count_ff <= held_count_in;
         held_digit_ff <= held_digit_in;
      end
   end

endmodule

>>> hdl/upc_fifo.sv
// Job queue between the front and back ends of the URI percent codec.
// Uses upc_pkg for the job and status types.
module upc_fifo
   import upc_pkg::*;
#(
   parameter int DEPTH = UPC_QUEUE_DEPTH
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  job_type         push_job,
   input  logic            pop,
   output job_type         head_job,
   output fifo_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_job     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> hdl/upc_back.sv
// Back end: walks the job at the head of the queue one byte per beat and
// marks the last byte of each item. Uses upc_pkg and upc_rsp_if.
module upc_back
   import upc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  job_type         head_job,
   input  fifo_status_type fifo_status,
   output logic            pop,
   upc_rsp_if.source       rsp
);

   logic [1:0] sel_ff, sel_in;
   logic       last_byte;
   logic       beat;

   assign last_byte    = (sel_ff == head_job.count - 2'd1);
   assign beat         = rsp.valid && rsp.ready;
   assign pop          = beat && last_byte;
   assign rsp.valid    = !fifo_status.empty;
   assign rsp.run_last = last_byte;
   assign rsp.out_end  = last_byte && head_job.str_end;

   always_comb begin
      unique case (sel_ff)
         2'd0:    rsp.out_byte = head_job.bytes[0];
         2'd1:    rsp.out_byte = head_job.bytes[1];
         default: rsp.out_byte = head_job.bytes[2];
      endcase
   end

   always_comb begin
      sel_in = sel_ff;
      if (pop) begin
         sel_in = 2'd0;
      end else if (beat) begin
         sel_in = sel_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 2'd0;
      end else begin
         sel_ff <= sel_in;
      end
   end

endmodule

>>> hdl/uri_percent_codec_core.sv
// Top level of the URI percent codec: configuration registers, front end,
// job queue and back end. Uses upc_pkg, upc_req_if, upc_rsp_if and submodules.
//
// Usage: write direction (index 0: 1 encodes, 0 decodes) and safe_set
// (index 1) on the csr_ port while the block is idle. Feed string bytes on
// req_chan, with string_end set on the last byte of each string; output
// bytes leave on rsp_chan, run_last marking the last byte that an input
// beat released and out_end the last byte of a string.
// An accepted job is registered in the queue before its first output byte
// is offered. A decoded byte that opens or continues an escape may release
// nothing until a later beat. The single output port moves one byte per
// cycle while rsp_chan is ready; an item releases one output byte for a
// safe or plain byte or a completed escape and three for an encoded one.
// The queue holds QUEUE_DEPTH jobs, so input keeps flowing while earlier
// results wait.
// When rsp_chan stalls, the queue fills and req_chan.ready drops once it
// is full. Reset clears the registers, the escape state and the queue.
module uri_percent_codec_core
   import upc_pkg::*;
#(
   parameter int QUEUE_DEPTH = UPC_QUEUE_DEPTH
)
(
   input  logic                   clock,
   input  logic                   reset,
   upc_req_if.sink                req_chan,
   upc_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type         cfg_ff, cfg_in;
   fifo_status_type fifo_status;
   job_type         push_job;
   job_type         head_job;
   logic            push;
   logic            pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DIRECTION: cfg_in.direction = csr_wdata[0];
            CSR_SAFE_SET:  cfg_in.safe_set  = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   upc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req         (req_chan),
      .fifo_status (fifo_status),
      .push        (push),
      .push_job    (push_job)
   );

   upc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (fifo_status)
   );

   upc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .fifo_status (fifo_status),
      .pop         (pop),
      .rsp         (rsp_chan)
   );

   // The final beat of a string always releases at least one byte.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.string_end) |=> rsp_chan.valid)
      else $error("string end produced no output");

   // Back pressure on the input only comes from a queue that holds work.
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid)
      else $error("input stalled with empty queue");

   // The end-of-string mark only rides on the last byte of an item.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.out_end) |-> rsp_chan.run_last)
      else $error("out_end without run_last");

endmodule

>>> tb/uri_percent_codec_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for uri_percent_codec_core: directed table, then random strings.
// Depends on upc_pkg, upc_req_if, upc_rsp_if and the codec RTL.
module uri_percent_codec_core_test;
   import upc_pkg::*;

   localparam int PREDICTED      = -1;    // table row checked against the predictor
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_PHASE_ITEMS = 62;

   typedef struct {
      logic [7:0] out_byte;
      logic       run_last;
      logic       out_end;
   } codec_beat_type;

   typedef struct {
      logic       dir;
      logic       safe;
      logic [7:0] in_byte;
      logic       str_end;
      int         n_out;
      logic [7:0] x0, x1, x2;
   } table_row_type;

   typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_CHOPPED} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   upc_req_if req_chan ();
   upc_rsp_if rsp_chan ();

   uri_percent_codec_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: mirrors the registers and the decoder's held escape.
   logic       cfg_direction;
   logic       cfg_safe_set;
   logic [1:0] held_count;
   logic [7:0] held_digit;
   logic [7:0] released_bytes[$];

   codec_beat_type pending_out_beats[$];
   table_row_type  stim_table[$];
   logic [7:0]     string_bytes[$];

   int  fail_count = 0;
   int  burst_left = 0;
   bit  sending    = 0;
   int  idle_cycles = 0;
   rx_mode_type rx_mode = RX_FREE;
   int  rx_seg_left = 0;

   function automatic int digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
   endfunction

   function automatic bit is_url_safe(input logic [7:0] c, input logic ext);
      bit alnum;
      alnum = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
      return alnum || c == "_" || (ext && (c == "-" || c == "." || c == "~"));
   endfunction

   function automatic logic [7:0] nibble_char(input logic [3:0] n);
      return (n < 10) ? 8'("0" + n) : 8'("A" + n - 10);
   endfunction

   task automatic emit_byte(input logic [7:0] c);
      if (released_bytes.size() < 3) released_bytes.push_back(c);
   endtask

   task automatic take_fresh(input logic [7:0] c);
      if (c == CHAR_PERCENT) begin
         held_count = HELD_PERCENT;
      end else begin
         held_count = HELD_NONE;
         emit_byte(c);
      end
   endtask

   // Works out the bytes that one input beat releases and updates the held escape.
   task automatic codec_step(input logic [7:0] b, input logic str_end);
      int v;
      int hv;
      released_bytes.delete();
      if (cfg_direction) begin
         held_count = HELD_NONE;
         if (is_url_safe(b, cfg_safe_set)) begin
            emit_byte(b);
         end else begin
            emit_byte(CHAR_PERCENT);
            emit_byte(nibble_char(b[7:4]));
            emit_byte(nibble_char(b[3:0]));
         end
      end else begin
         v = digit_value(b);
         case (held_count)
            HELD_PERCENT: begin
               if (v >= 0) begin
                  held_digit = b;
                  held_count = HELD_DIGIT;
               end else begin
                  emit_byte(CHAR_PERCENT);
                  take_fresh(b);
               end
            end
            HELD_DIGIT: begin
               hv = digit_value(held_digit);
               if (v >= 0 && hv >= 0) begin
                  emit_byte(8'((hv << 4) + v));
                  held_count = HELD_NONE;
               end else begin
                  emit_byte(CHAR_PERCENT);
                  emit_byte(held_digit);
                  take_fresh(b);
               end
            end
            default: take_fresh(b);
         endcase
         if (str_end) begin
            if (held_count == HELD_PERCENT) begin
               emit_byte(CHAR_PERCENT);
            end else if (held_count == HELD_DIGIT) begin
               emit_byte(CHAR_PERCENT);
               emit_byte(held_digit);
            end
            held_count = HELD_NONE;
         end
      end
   endtask

   task automatic add_row(input logic dir, input logic safe, input logic [7:0] b,
                          input logic e, input int n, input logic [7:0] x0 = 8'h00,
                          input logic [7:0] x1 = 8'h00, input logic [7:0] x2 = 8'h00);
      table_row_type row;
      row = '{dir, safe, b, e, n, x0, x1, x2};
      stim_table.push_back(row);
   endtask

   // Stops offering input, waits until every expected beat has come, then lets the design settle.
   task automatic wait_drained();
      if (sending) begin
         req_chan.valid <= 1'b0;
         sending = 0;
      end
      @(posedge clock);
      while (pending_out_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_codec_regs(input logic dir, input logic safe);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_DIRECTION;
      csr_wdata <= CSR_DATA_W'(dir);
      @(posedge clock);
      csr_index <= CSR_SAFE_SET;
      csr_wdata <= CSR_DATA_W'(safe);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_direction = dir;
      cfg_safe_set  = safe;
   endtask

   // Offers one beat, waits for it to be taken, and queues the bytes it should release.
   // A row with a typed result uses that instead of the predictor's bytes.
   task automatic drive_item(input logic [7:0] b, input logic e, input int n,
                             input logic [7:0] x0, input logic [7:0] x1,
                             input logic [7:0] x2);
      codec_beat_type beat;
      logic [7:0]     outs[$];
      req_chan.in_byte    <= b;
      req_chan.string_end <= e;
      req_chan.valid      <= 1'b1;
      sending = 1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      codec_step(b, e);
      if (n == PREDICTED) begin
         outs = released_bytes;
      end else begin
         outs = '{x0, x1, x2};
         outs = outs[0:n-1];
         if (n == 0) outs.delete();
      end
      foreach (outs[k]) begin
         beat.out_byte = outs[k];
         beat.run_last = (k == outs.size() - 1);
         beat.out_end  = beat.run_last && e;
         pending_out_beats.push_back(beat);
      end
      burst_left--;
      if (burst_left <= 0) begin
         req_chan.valid <= 1'b0;
         sending = 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
   endtask

   function automatic logic [7:0] rand_hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'("0" + v);
      return $urandom_range(0, 1) ? 8'("A" + v - 10) : 8'("a" + v - 10);
   endfunction

   function automatic logic [7:0] rand_non_hex();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (digit_value(c) >= 0);
      return c;
   endfunction

   // Well-formed escapes with random digits are the most common pick; the rest plain, broken or cut short.
   task automatic build_decode_string();
      int r;
      string_bytes.delete();
      repeat ($urandom_range(1, 8)) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            string_bytes.push_back(CHAR_PERCENT);
            string_bytes.push_back(rand_hex_char());
            string_bytes.push_back(rand_hex_char());
         end else if (r < 70) begin
            string_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (r < 85) begin
            string_bytes.push_back(CHAR_PERCENT);
            if ($urandom_range(0, 1)) string_bytes.push_back(rand_hex_char());
            string_bytes.push_back(rand_non_hex());
         end else begin
            string_bytes.push_back(CHAR_PERCENT);
            if ($urandom_range(0, 1)) string_bytes.push_back(rand_hex_char());
         end
      end
   endtask

   task automatic build_encode_string();
      int r;
      logic [7:0] specials[8];
      specials = '{"-", ".", "_", "~", CHAR_PERCENT, " ", 8'h00, 8'hFF};
      string_bytes.delete();
      repeat ($urandom_range(1, 8)) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            string_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (r < 70) begin
            string_bytes.push_back(specials[$urandom_range(0, 7)]);
         end else begin
            string_bytes.push_back(8'($urandom_range(0, 1) ? $urandom_range("a", "z")
                                                          : $urandom_range("0", "9")));
         end
      end
   endtask

   initial begin : stimulus
      logic phase_dir[8];
      logic phase_safe[8];
      int   phase_items;
      bit   paused;
      csr_we    = 1'b0;
      csr_index = CSR_DIRECTION;
      csr_wdata = '0;
      req_chan.valid      = 1'b0;
      req_chan.in_byte    = 8'h00;
      req_chan.string_end = 1'b0;
      cfg_direction = 1'b0;
      cfg_safe_set  = 1'b0;
      held_count    = HELD_NONE;
      held_digit    = 8'h00;
      burst_left    = $urandom_range(1, 40);

      // Decoding with the reset register values.
      add_row(0, 0, "A",   1, 1, "A");
      add_row(0, 0, 8'h00, 0, 1, 8'h00);
      add_row(0, 0, 8'hFF, 1, 1, 8'hFF);
      add_row(0, 0, "%",   0, 0);
      add_row(0, 0, "4",   0, 0);
      add_row(0, 0, "1",   1, 1, "A");
      add_row(0, 0, "%",   0, 0);
      add_row(0, 0, "f",   0, 0);
      add_row(0, 0, "F",   0, 1, 8'hFF);
      // Broken escapes, a percent after a percent, and flushes at the end of a string.
      add_row(0, 0, "%",   0, 0);
      add_row(0, 0, "G",   0, 2, "%", "G");
      add_row(0, 0, "%",   0, 0);
      add_row(0, 0, "a",   0, 0);
      add_row(0, 0, "z",   0, 3, "%", "a", "z");
      add_row(0, 0, "%",   0, 0);
      add_row(0, 0, "%",   0, 1, "%");
      add_row(0, 0, "7",   1, 2, "%", "7");
      add_row(0, 0, "%",   1, 1, "%");
      // The held percent is dropped by the first encode beat.
      add_row(0, 0, "%",   0, 0);
      add_row(1, 0, "a",   0, 1, "a");
      add_row(1, 0, "-",   0, 3, "%", "2", "D");
      add_row(1, 0, "_",   0, 1, "_");
      add_row(1, 0, 8'hFF, 1, 3, "%", "F", "F");
      add_row(1, 1, "-",   0, 1, "-");
      add_row(1, 1, "~",   0, 1, "~");
      add_row(1, 1, " ",   1, 3, "%", "2", "0");
      add_row(0, 1, "A",   1, 1, "A");
      add_row(0, 1, "%",   0, PREDICTED);
      add_row(0, 1, "b",   0, PREDICTED);
      add_row(0, 1, "3",   1, PREDICTED);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_table[i]) begin
         if (stim_table[i].dir != cfg_direction || stim_table[i].safe != cfg_safe_set)
            write_codec_regs(stim_table[i].dir, stim_table[i].safe);
         drive_item(stim_table[i].in_byte, stim_table[i].str_end, stim_table[i].n_out,
                    stim_table[i].x0, stim_table[i].x1, stim_table[i].x2);
      end

      phase_dir  = '{0, 1, 1, 0, 0, 1, 1, 0};
      phase_safe = '{0, 0, 1, 1, 0, 1, 0, 1};
      for (int p = 0; p < 8; p++) begin
         write_codec_regs(phase_dir[p], phase_safe[p]);
         phase_items = 0;
         paused = 0;
         while (phase_items < RANDOM_PHASE_ITEMS) begin
            if (cfg_direction) build_encode_string();
            else build_decode_string();
            foreach (string_bytes[k])
               drive_item(string_bytes[k], k == string_bytes.size() - 1, PREDICTED,
                          8'h00, 8'h00, 8'h00);
            phase_items += string_bytes.size();
            if (!paused && phase_items >= RANDOM_PHASE_ITEMS / 2) begin
               wait_drained();
               paused = 1;
            end
         end
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("uri_percent_codec_core regression: pass");
      end else begin
         $display("uri_percent_codec_core regression: fail");
      end
      $finish;
   end

   // The receiver switches between free flow, random stalls and a fixed chopped pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rx_seg_left    <= 0;
      end else if (rx_seg_left == 0) begin
         rx_mode        <= rx_mode_type'($urandom_range(0, 2));
         rx_seg_left    <= $urandom_range(8, 60);
         rsp_chan.ready <= 1'b1;
      end else begin
         rx_seg_left <= rx_seg_left - 1;
         case (rx_mode)
            RX_FREE:   rsp_chan.ready <= 1'b1;
            RX_RANDOM: rsp_chan.ready <= 1'($urandom_range(0, 1));
            default:   rsp_chan.ready <= (rx_seg_left % 8) > 4;
         endcase
      end
   end

   always @(posedge clock) begin : out_checker
      codec_beat_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_out_beats.size() == 0) begin
            $error("out_byte: expected no beat, actual %h", rsp_chan.out_byte);
            fail_count++;
         end else begin
            want = pending_out_beats.pop_front();
            if (rsp_chan.out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, actual %h", want.out_byte, rsp_chan.out_byte);
               fail_count++;
            end
            if (rsp_chan.run_last !== want.run_last) begin
               $error("run_last: expected %b, actual %b", want.run_last, rsp_chan.run_last);
               fail_count++;
            end
            if (rsp_chan.out_end !== want.out_end) begin
               $error("out_end: expected %b, actual %b", want.out_end, rsp_chan.out_end);
               fail_count++;
            end
         end
      end
   end

   // Ends the run if no beat moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("uri_percent_codec_core regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
